/* src/sras_pkg.sv */
`timescale 1ns / 1ps

package sras_pkg;

   // default sizes
   localparam int DEF_MAX_DIGITS   = 64;
   localparam int DEF_OPERAND_BITS = 63;

   // hard cap on digits per word, whatever MAX_DIGITS says
   localparam int RESULT_LIMIT = 63;

   // radix register
   localparam int          RADIX_BITS  = 6;
   localparam logic [5:0]  RADIX_MIN   = 6'd2;
   localparam logic [5:0]  RADIX_TOP   = 6'd62;
   localparam logic [5:0]  RADIX_RESET = 6'd10;

   // quotient bits retired per divider cycle
   localparam int DIV_BITS = 4;

   // operation codes
   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_SUB = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;         // capture a +/- b
      logic absolute;     // form sign and magnitude, clear digit count
      logic div_step;     // run one group of restoring division steps
      logic digit_write;  // store remainder as next digit
      logic rd_init;      // point reader at most significant digit
      logic fetch;        // read one digit from the store
      logic rd_next;      // move reader toward least significant digit
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic quotient_zero;
      logic count_full;
      logic read_last;
   } status_type;

endpackage

/* src/signed_radix_add_sub.sv */
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// request   req_kind, req_operand_a, req_operand_b        start high, busy low
// response  rsp_digit, rsp_negative, rsp_last             rsp_strobe, one cycle
// config    csr_write_data                                csr_write_enable
//
// The radix divider retires four quotient bits a cycle, and each digit is
// read back from the digit store and then shown. Reset is synchronous and
// leaves the radix at 10. Digits leave on rsp_strobe, with a fetch between
// them, and cannot be held off; busy stays high until the cycle after the
// last digit.

module signed_radix_add_sub import sras_pkg::*; #(
   parameter int MAX_DIGITS   = DEF_MAX_DIGITS,
   parameter int OPERAND_BITS = DEF_OPERAND_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [RADIX_BITS-1:0]          csr_write_data,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic signed [OPERAND_BITS-1:0] req_operand_a,
   input  logic signed [OPERAND_BITS-1:0] req_operand_b,
   output logic                           rsp_strobe,
   output logic [RADIX_BITS-1:0]          rsp_digit,
   output logic                           rsp_negative,
   output logic                           rsp_last
);

   cmd_type    cmd;
   status_type status;

   // sequence the add, division and read-back
   sras_ctrl #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // arithmetic, divider and digit store
   sras_datapath #(
      .MAX_DIGITS  (MAX_DIGITS),
      .OPERAND_BITS(OPERAND_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_kind        (req_kind),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .cmd             (cmd),
      .status          (status),
      .rsp_digit       (rsp_digit),
      .rsp_negative    (rsp_negative),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTH
   // a digit only leaves while a word is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("digit strobe while idle");

   // digits are spaced by a fetch state
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> !rsp_strobe && busy)
      else $error("digits not spaced or word ended early");

   // the last digit ends the word
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy)
      else $error("busy after last digit");

   // an accepted word does not produce a digit at once
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accept did not start work");
`endif

endmodule

/* src/sras_ctrl.sv */
`timescale 1ns / 1ps

module sras_ctrl import sras_pkg::*; #(
   parameter int OPERAND_BITS = DEF_OPERAND_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_strobe,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int STEPS     = (OPERAND_BITS + DIV_BITS - 1) / DIV_BITS;
   localparam int STEP_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABS,
      ST_DIV,
      ST_NEXT,
      ST_FETCH,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 strobe_ff, strobe_in;

   // decode commands from state
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.load = start;
         ST_ABS:   cmd.absolute = 1'b1;
         ST_DIV: begin
            cmd.div_step    = 1'b1;
            cmd.digit_write = (step_ff == STEP_LAST);
         end
         ST_NEXT:  cmd.rd_init = status.quotient_zero | status.count_full;
         ST_FETCH: cmd.fetch = 1'b1;
         ST_OUT:   cmd.rd_next = ~status.read_last;
         default:  cmd = '0;
      endcase
   end

   // next state, step count and strobe
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_ABS;
         end
         ST_ABS: begin
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_NEXT;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_NEXT: begin
            step_in = '0;
            if (status.quotient_zero | status.count_full) state_in = ST_FETCH;
            else state_in = ST_DIV;
         end
         ST_FETCH: begin
            strobe_in = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (status.read_last) state_in = ST_IDLE;
            else state_in = ST_FETCH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

/* src/sras_datapath.sv */
`timescale 1ns / 1ps

module sras_datapath import sras_pkg::*; #(
   parameter int MAX_DIGITS   = DEF_MAX_DIGITS,
   parameter int OPERAND_BITS = DEF_OPERAND_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [RADIX_BITS-1:0]          csr_write_data,
   input  logic                           req_kind,
   input  logic signed [OPERAND_BITS-1:0] req_operand_a,
   input  logic signed [OPERAND_BITS-1:0] req_operand_b,
   input  cmd_type                        cmd,
   output status_type                     status,
   output logic [RADIX_BITS-1:0]          rsp_digit,
   output logic                           rsp_negative,
   output logic                           rsp_last
);

   localparam int CAP       = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
   localparam int ADDR_BITS = $clog2(CAP);
   localparam int CNT_BITS  = $clog2(CAP + 1);
   localparam int STEPS     = (OPERAND_BITS + DIV_BITS - 1) / DIV_BITS;
   localparam int WORK_BITS = STEPS * DIV_BITS;
   localparam int SUM_BITS  = OPERAND_BITS + 1;

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [SUM_BITS-1:0]   abs_val;
   logic [OPERAND_BITS-1:0] mag;
   logic                  neg_ff;
   logic [WORK_BITS-1:0]  work_ff, step_work;
   logic [RADIX_BITS-1:0] rem_ff, step_rem;
   logic [RADIX_BITS:0]   step_acc;
   logic [CNT_BITS-1:0]   count_ff, count_less;
   logic [ADDR_BITS-1:0]  rd_ff;
   logic [RADIX_BITS-1:0] rdata_ff;
   logic [RADIX_BITS-1:0] digit_mem [CAP];

   // clamp radix writes into 2..62
   always_comb begin
      if (csr_write_data < RADIX_MIN) radix_in = RADIX_MIN;
      else if (csr_write_data > RADIX_TOP) radix_in = RADIX_TOP;
      else radix_in = csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) radix_ff <= RADIX_RESET;
      else if (csr_write_enable) radix_ff <= radix_in;
   end

   // exact sum or difference, one bit wider than the operands
   always_comb begin
      if (req_kind == KIND_SUB) begin
         sum_in = {req_operand_a[OPERAND_BITS-1], req_operand_a}
                - {req_operand_b[OPERAND_BITS-1], req_operand_b};
      end else begin
         sum_in = {req_operand_a[OPERAND_BITS-1], req_operand_a}
                + {req_operand_b[OPERAND_BITS-1], req_operand_b};
      end
   end

   // magnitude, saturate the one value that does not fit
   assign abs_val = sum_ff[SUM_BITS-1] ? (~sum_ff + SUM_BITS'(1)) : sum_ff;
   assign mag     = abs_val[SUM_BITS-1] ? '1 : abs_val[OPERAND_BITS-1:0];

   // restoring division by radix, DIV_BITS quotient bits per cycle
   always_comb begin
      step_work = work_ff;
      step_rem  = rem_ff;
      step_acc  = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         step_acc  = {step_rem, step_work[WORK_BITS-1]};
         step_work = {step_work[WORK_BITS-2:0], 1'b0};
         if (step_acc >= {1'b0, radix_ff}) begin
            step_acc     = step_acc - {1'b0, radix_ff};
            step_work[0] = 1'b1;
         end
         step_rem = step_acc[RADIX_BITS-1:0];
      end
   end

   assign count_less = count_ff - CNT_BITS'(1);

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) sum_ff <= sum_in;
      if (cmd.absolute) begin
         neg_ff  <= sum_ff[SUM_BITS-1];
         work_ff <= WORK_BITS'(mag);
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         work_ff <= step_work;
         rem_ff  <= cmd.digit_write ? '0 : step_rem;
      end
      if (cmd.rd_init) rd_ff <= count_less[ADDR_BITS-1:0];
      else if (cmd.rd_next) rd_ff <= rd_ff - ADDR_BITS'(1);
   end

   // digit count
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.absolute) count_ff <= '0;
      else if (cmd.digit_write) count_ff <= count_ff + CNT_BITS'(1);
   end

   // digit store, least significant first
   always_ff @(posedge clock) begin
      if (cmd.digit_write) digit_mem[count_ff[ADDR_BITS-1:0]] <= step_rem;
      if (cmd.fetch) rdata_ff <= digit_mem[rd_ff];
   end

   assign status.quotient_zero = (work_ff == '0);
   assign status.count_full    = (count_ff == CNT_BITS'(CAP));
   assign status.read_last     = (rd_ff == '0);

   assign rsp_digit    = rdata_ff;
   assign rsp_negative = neg_ff;
   assign rsp_last     = (rd_ff == '0);

endmodule
